// ===== rtl/core/tscr_pkg.sv =====
package tscr_pkg;

  localparam int SCALE_COEF = 100;
  localparam int RAW_SHIFT  = 3;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 2 * BYTE_W;
  localparam int RAW_W      = WORD_W - RAW_SHIFT;
  localparam int DATA_W     = 32;
  localparam int TURN_W     = 2;
  localparam int SCREEN_W   = 16;
  localparam int ADDR_W     = 5;

  // quotient bits resolved per divider stage
  localparam int DIV_STEP   = 2;
  localparam int NUM_BITS   = $clog2((1 << RAW_W) * SCALE_COEF);
  localparam int DIV_STAGES = (NUM_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int NUM_W      = DIV_STAGES * DIV_STEP;
  localparam int PIPE_DEPTH = DIV_STAGES + 3;

  localparam logic [DATA_W-1:0]   GAIN_RST   = DATA_W'(1);
  localparam logic [DATA_W-1:0]   OFFSET_RST = '0;
  localparam logic [TURN_W-1:0]   TURN_RST   = '0;
  localparam logic [SCREEN_W-1:0] WIDTH_RST  = SCREEN_W'(320);
  localparam logic [SCREEN_W-1:0] HEIGHT_RST = SCREEN_W'(240);

  typedef enum logic [2:0] {
    REG_X_GAIN        = 3'd0,
    REG_Y_GAIN        = 3'd1,
    REG_X_OFFSET      = 3'd2,
    REG_Y_OFFSET      = 3'd3,
    REG_SCREEN_TURN   = 3'd4,
    REG_SCREEN_WIDTH  = 3'd5,
    REG_SCREEN_HEIGHT = 3'd6
  } reg_idx_t;

  typedef enum logic [TURN_W-1:0] {
    TURN_TOP    = 2'd0,
    TURN_RIGHT  = 2'd1,
    TURN_BOTTOM = 2'd2,
    TURN_LEFT   = 2'd3
  } turn_t;

  typedef struct packed {
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  rem;
    logic [NUM_W-1:0]  quo;
    logic [DATA_W-1:0] dmag;
    logic              neg;
    logic              zero;
  } div_axis_t;

  typedef struct packed {
    logic      pen;
    div_axis_t x;
    div_axis_t y;
  } div_stage_t;

  typedef struct packed {
    logic              pen;
    logic              err;
    logic [DATA_W-1:0] cx;
    logic [DATA_W-1:0] cy;
  } cal_stage_t;

  function automatic div_axis_t div_step(div_axis_t a);
    div_axis_t         r;
    logic [NUM_W:0]    sh;
    logic [DATA_W-1:0] sh_ext;
    logic [DATA_W-1:0] diff;
    logic              ge;
    r = a;
    for (int k = 0; k < DIV_STEP; k++) begin
      sh     = {r.rem, r.num[NUM_W-1]};
      sh_ext = DATA_W'(sh);
      ge     = (sh_ext >= r.dmag);
      diff   = sh_ext - r.dmag;
      r.num  = {r.num[NUM_W-2:0], 1'b0};
      r.rem  = ge ? diff[NUM_W-1:0] : sh[NUM_W-1:0];
      r.quo  = {r.quo[NUM_W-2:0], ge};
    end
    return r;
  endfunction

  function automatic div_axis_t axis_load(logic [BYTE_W-1:0] hi, logic [BYTE_W-1:0] lo,
                                          logic [DATA_W-1:0] gain);
    div_axis_t         r;
    logic [WORD_W-1:0] word;
    logic [RAW_W-1:0]  raw;
    word   = {hi, lo};
    raw    = word[WORD_W-1:RAW_SHIFT];
    r.num  = NUM_W'(raw) * NUM_W'(SCALE_COEF);
    r.rem  = '0;
    r.quo  = '0;
    r.neg  = gain[DATA_W-1];
    r.dmag = gain[DATA_W-1] ? (DATA_W'(0) - gain) : gain;
    r.zero = (gain == '0);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] axis_finish(div_axis_t a, logic [DATA_W-1:0] offset);
    logic [DATA_W-1:0] q;
    q = DATA_W'(a.quo);
    if (a.neg) q = DATA_W'(0) - q;
    return a.zero ? '0 : (q + offset);
  endfunction

endpackage

// ===== rtl/core/tscr_in_if.sv =====
interface tscr_in_if;
  logic                     valid;
  logic                     ready;
  logic                     pen_down;
  logic [tscr_pkg::BYTE_W-1:0] x_high_byte;
  logic [tscr_pkg::BYTE_W-1:0] x_low_byte;
  logic [tscr_pkg::BYTE_W-1:0] y_high_byte;
  logic [tscr_pkg::BYTE_W-1:0] y_low_byte;

  modport source (output valid, pen_down, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
                  input ready);
  modport sink (input valid, pen_down, x_high_byte, x_low_byte, y_high_byte, y_low_byte,
                output ready);
endinterface

// ===== rtl/core/tscr_out_if.sv =====
interface tscr_out_if;
  logic                               valid;
  logic                               ready;
  logic                               touch_valid;
  logic signed [tscr_pkg::DATA_W-1:0] x_pos;
  logic signed [tscr_pkg::DATA_W-1:0] y_pos;
  logic                               gain_error;

  modport source (output valid, touch_valid, x_pos, y_pos, gain_error, input ready);
  modport sink (input valid, touch_valid, x_pos, y_pos, gain_error, output ready);
endinterface

// ===== rtl/core/touch_sample_calibrate_rotate_unit.sv =====
// touch sample calibration and rotation
//
// in_s carries one touch sample per transfer: pen_down and the two bytes of
// each axis conversion. out_m carries one result per sample, in order:
// touch_valid, x_pos, y_pos and gain_error.
// registers are written over the apb port (gains, offsets, turn, screen size)
// at byte address 4*index; they must only be changed while no sample is in
// flight, a rule for the user that the block itself does not enforce.
//
// the pipeline has one load stage, ten restoring divider stages resolving two
// quotient bits each, one offset stage and one rotation stage that is also
// the output register. throughput is one sample per cycle while out_m.ready
// does not stall the pipeline, set by the fully pipelined divider.
//
// when out_m.ready is low the last stage holds its result; earlier stages keep
// moving until they meet a full stage, so in_s.ready only drops once every
// stage holds a sample.
// reset (rst_n low, synchronous) empties the pipeline and restores the
// register defaults: gains 1, offsets 0, turn top, screen 320 x 240.
module touch_sample_calibrate_rotate_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  tscr_in_if.sink                       in_s,
  tscr_out_if.source                    out_m,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tscr_pkg::ADDR_W-1:0]   paddr,
  input  logic [tscr_pkg::DATA_W-1:0]   pwdata,
  output logic [tscr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import tscr_pkg::*;

  localparam int LAST = PIPE_DEPTH - 1;
  localparam int CAL  = PIPE_DEPTH - 2;

  logic [DATA_W-1:0]   x_gain_r, y_gain_r, x_offset_r, y_offset_r;
  logic [TURN_W-1:0]   screen_turn_r;
  logic [SCREEN_W-1:0] screen_width_r, screen_height_r;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_gain_r        <= GAIN_RST;
      y_gain_r        <= GAIN_RST;
      x_offset_r      <= OFFSET_RST;
      y_offset_r      <= OFFSET_RST;
      screen_turn_r   <= TURN_RST;
      screen_width_r  <= WIDTH_RST;
      screen_height_r <= HEIGHT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_X_GAIN:        x_gain_r        <= pwdata;
        REG_Y_GAIN:        y_gain_r        <= pwdata;
        REG_X_OFFSET:      x_offset_r      <= pwdata;
        REG_Y_OFFSET:      y_offset_r      <= pwdata;
        REG_SCREEN_TURN:   screen_turn_r   <= pwdata[TURN_W-1:0];
        REG_SCREEN_WIDTH:  screen_width_r  <= pwdata[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= pwdata[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_X_GAIN:        prdata = x_gain_r;
      REG_Y_GAIN:        prdata = y_gain_r;
      REG_X_OFFSET:      prdata = x_offset_r;
      REG_Y_OFFSET:      prdata = y_offset_r;
      REG_SCREEN_TURN:   prdata = DATA_W'(screen_turn_r);
      REG_SCREEN_WIDTH:  prdata = DATA_W'(screen_width_r);
      REG_SCREEN_HEIGHT: prdata = DATA_W'(screen_height_r);
      default:           prdata = '0;
    endcase
  end

  // pipeline control: a stage moves when empty or when the next one moves
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] adv;

  always_comb begin
    adv[LAST] = !vld_r[LAST] || out_m.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_s.ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_s.valid;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // load stage and divider stages
  div_stage_t div_r [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      div_r[0].pen <= in_s.pen_down;
      div_r[0].x   <= axis_load(in_s.x_high_byte, in_s.x_low_byte, x_gain_r);
      div_r[0].y   <= axis_load(in_s.y_high_byte, in_s.y_low_byte, y_gain_r);
    end
    for (int i = 1; i <= DIV_STAGES; i++) begin
      if (adv[i]) begin
        div_r[i].pen <= div_r[i-1].pen;
        div_r[i].x   <= div_step(div_r[i-1].x);
        div_r[i].y   <= div_step(div_r[i-1].y);
      end
    end
  end

  // sign, zero gain and offset
  cal_stage_t cal_r;

  always_ff @(posedge clk) begin
    if (adv[CAL]) begin
      cal_r.pen <= div_r[DIV_STAGES].pen;
      cal_r.err <= div_r[DIV_STAGES].x.zero || div_r[DIV_STAGES].y.zero;
      cal_r.cx  <= axis_finish(div_r[DIV_STAGES].x, x_offset_r);
      cal_r.cy  <= axis_finish(div_r[DIV_STAGES].y, y_offset_r);
    end
  end

  // rotation into the output register
  logic [DATA_W-1:0] wid_ext, hgt_ext;
  logic [DATA_W-1:0] rx_nxt, ry_nxt;
  logic              tv_r, err_r;
  logic [DATA_W-1:0] rx_r, ry_r;

  assign wid_ext = DATA_W'(screen_width_r);
  assign hgt_ext = DATA_W'(screen_height_r);

  always_comb begin
    unique case (turn_t'(screen_turn_r))
      TURN_RIGHT: begin
        rx_nxt = cal_r.cy;
        ry_nxt = wid_ext - cal_r.cx;
      end
      TURN_BOTTOM: begin
        rx_nxt = wid_ext - cal_r.cx;
        ry_nxt = hgt_ext - cal_r.cy;
      end
      TURN_LEFT: begin
        rx_nxt = hgt_ext - cal_r.cy;
        ry_nxt = cal_r.cx;
      end
      default: begin
        rx_nxt = cal_r.cx;
        ry_nxt = cal_r.cy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[LAST]) begin
      tv_r  <= cal_r.pen;
      err_r <= cal_r.pen && cal_r.err;
      rx_r  <= cal_r.pen ? rx_nxt : '0;
      ry_r  <= cal_r.pen ? ry_nxt : '0;
    end
  end

  assign out_m.valid       = vld_r[LAST];
  assign out_m.touch_valid = tv_r;
  assign out_m.gain_error  = err_r;
  assign out_m.x_pos       = rx_r;
  assign out_m.y_pos       = ry_r;

  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_s.ready |-> (&vld_r))
    else $error("input blocked with an empty stage");

  a_pen_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && !out_m.touch_valid |->
      out_m.x_pos == '0 && out_m.y_pos == '0 && !out_m.gain_error)
    else $error("pen up result not cleared");

  a_cal_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[CAL] && !adv[CAL] |=> vld_r[CAL] && $stable(cal_r))
    else $error("stalled offset stage changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_m.valid && !out_m.ready |=> out_m.valid && $stable(rx_r) && $stable(ry_r))
    else $error("stalled result changed");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import tscr_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_SAMPLES = 135;
  localparam int CALM_PHASE    = 3;
  localparam int SHOW_LIMIT    = 10;
  localparam logic [2:0]        REG_NONE = 3'd7;
  localparam logic [DATA_W-1:0] INT_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] INT_MAX  = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic              pen;
    logic [BYTE_W-1:0] xh;
    logic [BYTE_W-1:0] xl;
    logic [BYTE_W-1:0] yh;
    logic [BYTE_W-1:0] yl;
  } touch_sample_t;

  typedef struct packed {
    logic              touch;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic              err;
  } touch_result_t;

  bit                 clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]  pwdata;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  bit                 no_gaps = 1'b0;

  tscr_in_if  in_bus ();
  tscr_out_if out_bus ();

  // calibration settings as the block should hold them
  logic [DATA_W-1:0]   gain_x   = GAIN_RST;
  logic [DATA_W-1:0]   gain_y   = GAIN_RST;
  logic [DATA_W-1:0]   offset_x = OFFSET_RST;
  logic [DATA_W-1:0]   offset_y = OFFSET_RST;
  turn_t               turn_sel = TURN_TOP;
  logic [SCREEN_W-1:0] width    = WIDTH_RST;
  logic [SCREEN_W-1:0] height   = HEIGHT_RST;

  touch_sample_t pending_samples[$];
  touch_result_t expected_results[$];
  touch_sample_t next_sample;
  touch_sample_t offered;
  touch_result_t got;
  touch_result_t want;

  int samples_added;
  int samples_sent;
  int results_checked;
  int touches_seen;
  int gain_errors_seen;
  int settings_written;
  int fault_count;
  int stall_cycles;

  touch_sample_calibrate_rotate_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_bus),
    .out_m   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] calibrate_axis(
    input logic [BYTE_W-1:0] hi, input logic [BYTE_W-1:0] lo,
    input logic [DATA_W-1:0] gain, input logic [DATA_W-1:0] offset);
    logic [WORD_W-1:0] word;
    logic [DATA_W-1:0] scaled;
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] quo;
    word   = {hi, lo};
    scaled = DATA_W'(word >> RAW_SHIFT) * DATA_W'(SCALE_COEF);
    if (gain == '0) return '0;
    mag = gain[DATA_W-1] ? (DATA_W'(0) - gain) : gain;
    quo = scaled / mag;
    if (gain[DATA_W-1]) quo = DATA_W'(0) - quo;
    return quo + offset;
  endfunction

  function automatic touch_result_t predict_touch(input touch_sample_t s);
    touch_result_t     r;
    logic [DATA_W-1:0] cx;
    logic [DATA_W-1:0] cy;
    logic [DATA_W-1:0] w32;
    logic [DATA_W-1:0] h32;
    r = '0;
    if (!s.pen) return r;
    cx  = calibrate_axis(s.xh, s.xl, gain_x, offset_x);
    cy  = calibrate_axis(s.yh, s.yl, gain_y, offset_y);
    w32 = DATA_W'(width);
    h32 = DATA_W'(height);
    r.touch = 1'b1;
    r.err   = (gain_x == '0) || (gain_y == '0);
    case (turn_sel)
      TURN_RIGHT: begin
        r.x = cy;
        r.y = w32 - cx;
      end
      TURN_BOTTOM: begin
        r.x = w32 - cx;
        r.y = h32 - cy;
      end
      TURN_LEFT: begin
        r.x = h32 - cy;
        r.y = cx;
      end
      default: begin
        r.x = cx;
        r.y = cy;
      end
    endcase
    return r;
  endfunction

  task automatic note_fault(input string what, input touch_result_t e,
                            input touch_result_t a);
    fault_count++;
    if (fault_count <= SHOW_LIMIT) begin
      $display("%0t %s: expected valid=%0b x=%0d y=%0d err=%0b", $time, what,
               e.touch, $signed(e.x), $signed(e.y), e.err);
      $display("    got valid=%0b x=%0d y=%0d err=%0b",
               a.touch, $signed(a.x), $signed(a.y), a.err);
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        offered.pen = in_bus.pen_down;
        offered.xh  = in_bus.x_high_byte;
        offered.xl  = in_bus.x_low_byte;
        offered.yh  = in_bus.y_high_byte;
        offered.yl  = in_bus.y_low_byte;
        expected_results.push_back(predict_touch(offered));
        samples_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_samples.size() != 0 && (no_gaps || $urandom_range(99) >= 7)) begin
          next_sample = pending_samples.pop_front();
          in_bus.pen_down    <= next_sample.pen;
          in_bus.x_high_byte <= next_sample.xh;
          in_bus.x_low_byte  <= next_sample.xl;
          in_bus.y_high_byte <= next_sample.yh;
          in_bus.y_low_byte  <= next_sample.yl;
          in_bus.valid       <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.touch = out_bus.touch_valid;
        got.x     = out_bus.x_pos;
        got.y     = out_bus.y_pos;
        got.err   = out_bus.gain_error;
        if (expected_results.size() == 0) begin
          note_fault("result with nothing expected", '0, got);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.touch) touches_seen++;
          if (want.err) gain_errors_seen++;
          if (got.touch !== want.touch || got.x !== want.x || got.y !== want.y ||
              got.err !== want.err)
            note_fault("mismatch", want, got);
        end
      end
      out_bus.ready <= no_gaps || ($urandom_range(99) >= 7);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_X_GAIN:        gain_x   = val;
      REG_Y_GAIN:        gain_y   = val;
      REG_X_OFFSET:      offset_x = val;
      REG_Y_OFFSET:      offset_y = val;
      REG_SCREEN_TURN:   turn_sel = turn_t'(val[TURN_W-1:0]);
      REG_SCREEN_WIDTH:  width    = val[SCREEN_W-1:0];
      REG_SCREEN_HEIGHT: height   = val[SCREEN_W-1:0];
      default: ;
    endcase
    settings_written++;
  endtask

  // every queued sample has transferred and its result has been checked
  task automatic settle();
    while (pending_samples.size() != 0 || samples_sent != samples_added ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic add_sample(input logic pen, input logic [BYTE_W-1:0] xh,
                            input logic [BYTE_W-1:0] xl, input logic [BYTE_W-1:0] yh,
                            input logic [BYTE_W-1:0] yl);
    touch_sample_t s;
    s.pen = pen;
    s.xh  = xh;
    s.xl  = xl;
    s.yh  = yh;
    s.yl  = yl;
    pending_samples.push_back(s);
    samples_added++;
  endtask

  task automatic add_corner_samples();
    add_sample(1'b1, 8'hff, 8'hff, 8'hff, 8'hff);
    add_sample(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    add_sample(1'b1, 8'h80, 8'h07, 8'h00, 8'hf8);
    add_sample(1'b0, 8'haa, 8'h55, 8'haa, 8'h55);
    add_sample(1'b1, 8'h12, 8'h34, 8'h56, 8'h78);
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    logic [DATA_W-1:0] mag;
    mag = DATA_W'($urandom_range(1, 2000));
    case ($urandom_range(9))
      0: return '0;
      1: return INT_MIN;
      2: return ALL_ONES;
      3: return $urandom();
      4: return INT_MAX;
      default: return $urandom_range(1) ? (DATA_W'(0) - mag) : mag;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_offset();
    if ($urandom_range(3) == 0) return $urandom();
    return DATA_W'($urandom_range(2000)) - DATA_W'(1000);
  endfunction

  // upper bits carry junk, the block keeps only the register width
  function automatic logic [DATA_W-1:0] pick_size();
    logic [DATA_W-1:0] r;
    r = $urandom();
    case ($urandom_range(5))
      0: r[SCREEN_W-1:0] = '0;
      1: r[SCREEN_W-1:0] = '1;
      2: ;
      default: r[SCREEN_W-1:0] = SCREEN_W'($urandom_range(1, 2000));
    endcase
    return r;
  endfunction

  task automatic randomize_settings();
    write_reg(REG_X_GAIN, pick_gain());
    write_reg(REG_Y_GAIN, pick_gain());
    write_reg(REG_X_OFFSET, pick_offset());
    write_reg(REG_Y_OFFSET, pick_offset());
    write_reg(REG_SCREEN_TURN, $urandom());
    write_reg(REG_SCREEN_WIDTH, pick_size());
    write_reg(REG_SCREEN_HEIGHT, pick_size());
  endtask

  task automatic add_random_samples(input int n);
    repeat (n)
      add_sample($urandom_range(99) < 85, BYTE_W'($urandom()), BYTE_W'($urandom()),
                 BYTE_W'($urandom()), BYTE_W'($urandom()));
  endtask

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_bus.valid       = 1'b0;
    in_bus.pen_down    = 1'b0;
    in_bus.x_high_byte = '0;
    in_bus.x_low_byte  = '0;
    in_bus.y_high_byte = '0;
    in_bus.y_low_byte  = '0;
    out_bus.ready      = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings
    add_sample(1'b0, 8'hff, 8'hff, 8'hff, 8'hff);
    add_corner_samples();
    settle();

    // zero x gain, y gain of minus one, offsets at the extremes
    write_reg(REG_NONE, 32'hdead_beef);
    write_reg(REG_X_GAIN, '0);
    write_reg(REG_Y_GAIN, ALL_ONES);
    write_reg(REG_X_OFFSET, INT_MAX);
    write_reg(REG_Y_OFFSET, INT_MIN);
    write_reg(REG_SCREEN_TURN, DATA_W'(TURN_RIGHT));
    write_reg(REG_SCREEN_WIDTH, 32'h0000_ffff);
    write_reg(REG_SCREEN_HEIGHT, '0);
    add_corner_samples();
    settle();

    write_reg(REG_X_GAIN, INT_MIN);
    write_reg(REG_Y_GAIN, '0);
    write_reg(REG_X_OFFSET, ALL_ONES);
    write_reg(REG_Y_OFFSET, 32'd1);
    write_reg(REG_SCREEN_TURN, DATA_W'(TURN_BOTTOM));
    write_reg(REG_SCREEN_WIDTH, '0);
    write_reg(REG_SCREEN_HEIGHT, 32'hffff_ffff);
    add_corner_samples();
    settle();

    write_reg(REG_X_GAIN, INT_MAX);
    write_reg(REG_Y_GAIN, 32'd3);
    write_reg(REG_X_OFFSET, 32'hffff_ff9c);
    write_reg(REG_SCREEN_TURN, DATA_W'(TURN_LEFT));
    write_reg(REG_SCREEN_WIDTH, 32'd320);
    write_reg(REG_SCREEN_HEIGHT, 32'd240);
    add_corner_samples();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      randomize_settings();
      no_gaps <= (p == CALM_PHASE);
      add_random_samples(PHASE_SAMPLES);
    end
    settle();

    $display("sent %0d samples, checked %0d results (%0d with pen down, %0d gain errors)",
             samples_sent, results_checked, touches_seen, gain_errors_seen);
    $display("over %0d register writes across %0d settings, %0d faults",
             settings_written, RANDOM_PHASES + 4, fault_count);
    if (fault_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
